// ===== hdl/sfa_pkg.sv =====
// shared types and constants of the secp256k1 field arithmetic unit
package sfa_pkg;

	typedef logic [255:0] elem_t;

	localparam elem_t PRIME    = 256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
	localparam elem_t EXP_INV  = 256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2D;
	localparam elem_t EXP_SQRT = 256'h3FFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_BFFFFF0C;
	localparam elem_t FOLD_C   = 256'h1_000003D1;

	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_NEG  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_SQR  = 3'd4;
	localparam logic [2:0] OP_RED  = 3'd5;
	localparam logic [2:0] OP_INV  = 3'd6;
	localparam logic [2:0] OP_SQRT = 3'd7;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVZERO = 2'd1;
	localparam logic [1:0] ST_NONRES  = 2'd2;

	// multiplier status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

endpackage

// ===== hdl/sfa_if.sv =====
// transfer channels of the field arithmetic unit
interface sfa_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [63:0] a_limb0;
	logic [63:0] a_limb1;
	logic [63:0] a_limb2;
	logic [63:0] a_limb3;
	logic [63:0] b_limb0;
	logic [63:0] b_limb1;
	logic [63:0] b_limb2;
	logic [63:0] b_limb3;
	modport source (output valid, action, a_limb0, a_limb1, a_limb2, a_limb3,
		b_limb0, b_limb1, b_limb2, b_limb3, input ready);
	modport sink (input valid, action, a_limb0, a_limb1, a_limb2, a_limb3,
		b_limb0, b_limb1, b_limb2, b_limb3, output ready);
endinterface

interface sfa_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] res_limb0;
	logic [63:0] res_limb1;
	logic [63:0] res_limb2;
	logic [63:0] res_limb3;
	logic [1:0]  status;
	modport source (output valid, res_limb0, res_limb1, res_limb2, res_limb3, status,
		input ready);
	modport sink (input valid, res_limb0, res_limb1, res_limb2, res_limb3, status,
		output ready);
endinterface

// ===== hdl/sfa_modadd.sv =====
// modular add or subtract of two field elements
module sfa_modadd (
	input  sfa_pkg::elem_t x,
	input  sfa_pkg::elem_t y,
	input  logic           sub,
	output sfa_pkg::elem_t r
);
	import sfa_pkg::*;

	logic [256:0] sum;
	logic [256:0] sum_p;
	logic [256:0] dif;
	elem_t        dif_p;

	always_comb begin
		sum   = {1'b0, x} + {1'b0, y};
		sum_p = sum - {1'b0, PRIME};
		dif   = {1'b0, x} - {1'b0, y};
		dif_p = dif[255:0] + PRIME;
		if (sub) begin
			r = dif[256] ? dif_p : dif[255:0];
		end else begin
			// no borrow means sum not below the prime
			r = sum_p[256] ? sum[255:0] : sum_p[255:0];
		end
	end
endmodule

// ===== hdl/sfa_mulser.sv =====
// bit-serial modular multiplier, double then add, msb of x first
module sfa_mulser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  sfa_pkg::elem_t     x,
	input  sfa_pkg::elem_t     y,
	output sfa_pkg::elem_t     prod,
	output sfa_pkg::mul_stat_t stat
);
	import sfa_pkg::*;

	elem_t      x_q;
	elem_t      y_q;
	elem_t      acc_q;
	logic [7:0] cnt_q;
	logic       phase_q;
	logic       busy_q;
	logic       done_q;
	elem_t      add_y;
	elem_t      add_r;

	assign add_y = phase_q ? (x_q[255] ? y_q : '0) : acc_q;

	sfa_modadd u_add (.x(acc_q), .y(add_y), .sub(1'b0), .r(add_r));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			// one-cycle pulse after the last add step
			done_q <= busy_q && phase_q && (cnt_q == 8'd255);
			if (!busy_q) begin
				if (start) begin
					busy_q  <= 1'b1;
					phase_q <= 1'b0;
					cnt_q   <= '0;
				end
			end else begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q == 8'd255) begin
						busy_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (start) begin
				x_q   <= x;
				y_q   <= y;
				acc_q <= '0;
			end
		end else begin
			acc_q <= add_r;
			if (phase_q) x_q <= {x_q[254:0], 1'b0};
		end
	end

	assign prod      = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

// ===== hdl/secp256k1_field_alu.sv =====
// secp256k1 prime field arithmetic unit, top level
// inverse and sqrt: one serial multiplication per exponent bit plus one per set bit, and sqrt
// squares the root back to check it; one item at a time, a request is taken only in the idle state
// the next item is taken while a finished result waits in the output register
// reset: arst_n clears the sequencer, the multiplier control and the output valid flag
module secp256k1_field_alu (
	input logic         clk,
	input logic         arst_n,
	sfa_req_if.sink     req,
	sfa_rsp_if.source   rsp
);
	import sfa_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_REDA   = 4'd1;
	localparam logic [3:0] S_REDB   = 4'd2;
	localparam logic [3:0] S_EXEC   = 4'd3;
	localparam logic [3:0] S_MULW   = 4'd4;
	localparam logic [3:0] S_RADD   = 4'd5;
	localparam logic [3:0] S_PSQ_GO = 4'd6;
	localparam logic [3:0] S_PSQ_W  = 4'd7;
	localparam logic [3:0] S_PMU_GO = 4'd8;
	localparam logic [3:0] S_PMU_W  = 4'd9;
	localparam logic [3:0] S_CHK_GO = 4'd10;
	localparam logic [3:0] S_CHK_W  = 4'd11;
	localparam logic [3:0] S_FIN    = 4'd12;

	logic [3:0] state_q;
	logic [2:0] op_q;
	elem_t      a_q;
	elem_t      b_q;
	elem_t      ra_q;
	elem_t      rb_q;
	elem_t      acc_q;
	elem_t      res_q;
	logic [1:0] stat_q;
	logic [7:0] bit_q;
	logic       out_vld_q;
	elem_t      out_res_q;
	logic [1:0] out_stat_q;

	// shared modular adder for operand reduction, add, sub and neg, and the last step of reduce512
	elem_t      ax;
	elem_t      ay;
	logic       asub;
	elem_t      ar;

	// serial multiplier
	logic       m_start;
	elem_t      mx;
	elem_t      my;
	elem_t      mprod;
	mul_stat_t  mstat;
	logic       ebit;
	logic       out_free;

	sfa_modadd u_add (.x(ax), .y(ay), .sub(asub), .r(ar));

	sfa_mulser u_mul (
		.clk(clk), .arst_n(arst_n), .start(m_start),
		.x(mx), .y(my), .prod(mprod), .stat(mstat)
	);

	assign req.ready = (state_q == S_IDLE);
	assign out_free  = !out_vld_q || rsp.ready;
	assign ebit      = (op_q == OP_INV) ? EXP_INV[bit_q] : EXP_SQRT[bit_q];

	// adder operand selection
	always_comb begin
		ax   = '0;
		ay   = '0;
		asub = 1'b0;
		unique case (state_q)
			S_REDA: ax = a_q;
			S_REDB: ax = b_q;
			S_RADD: begin
				ax = res_q;
				ay = ra_q;
			end
			default: begin
				ax   = (op_q == OP_NEG) ? '0 : ra_q;
				ay   = (op_q == OP_NEG) ? ra_q : rb_q;
				asub = (op_q == OP_SUB) || (op_q == OP_NEG);
			end
		endcase
	end

	// multiplier operand selection
	always_comb begin
		m_start = 1'b0;
		mx      = acc_q;
		my      = acc_q;
		unique case (state_q)
			S_EXEC: begin
				m_start = (op_q == OP_MUL) || (op_q == OP_SQR) || (op_q == OP_RED);
				mx      = (op_q == OP_RED) ? b_q : ra_q;
				my      = (op_q == OP_RED) ? FOLD_C : ((op_q == OP_SQR) ? ra_q : rb_q);
			end
			S_PSQ_GO, S_CHK_GO: m_start = 1'b1;
			S_PMU_GO: begin
				m_start = 1'b1;
				my      = ra_q;
			end
			default: m_start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
			bit_q     <= '0;
		end else begin
			// output register loads from the finish state, empties on a transfer
			if (state_q == S_FIN && out_free) out_vld_q <= 1'b1;
			else if (rsp.ready) out_vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (req.valid) state_q <= S_REDA;
				S_REDA: state_q <= S_REDB;
				S_REDB: state_q <= S_EXEC;
				S_EXEC: begin
					case (op_q)
						OP_MUL, OP_SQR, OP_RED: state_q <= S_MULW;
						OP_INV: begin
							bit_q   <= 8'd255;
							state_q <= (ra_q == '0) ? S_FIN : S_PSQ_GO;
						end
						OP_SQRT: begin
							bit_q   <= 8'd255;
							state_q <= S_PSQ_GO;
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_MULW: if (mstat.done) state_q <= (op_q == OP_RED) ? S_RADD : S_FIN;
				S_RADD: state_q <= S_FIN;
				S_PSQ_GO, S_PMU_GO, S_CHK_GO: state_q <= state_q + 4'd1;
				S_PSQ_W, S_PMU_W: begin
					if (mstat.done) begin
						if (state_q == S_PSQ_W && ebit) begin
							state_q <= S_PMU_GO;
						end else if (bit_q == 8'd0) begin
							state_q <= (op_q == OP_INV) ? S_FIN : S_CHK_GO;
						end else begin
							bit_q   <= bit_q - 8'd1;
							state_q <= S_PSQ_GO;
						end
					end
				end
				S_CHK_W: if (mstat.done) state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q   <= req.action;
				a_q    <= {req.a_limb3, req.a_limb2, req.a_limb1, req.a_limb0};
				b_q    <= {req.b_limb3, req.b_limb2, req.b_limb1, req.b_limb0};
				stat_q <= ST_OK;
			end
			S_REDA: ra_q <= ar;
			S_REDB: rb_q <= ar;
			S_EXEC: begin
				acc_q <= 256'd1;
				if (op_q == OP_INV && ra_q == '0) begin
					res_q  <= '0;
					stat_q <= ST_INVZERO;
				end else begin
					res_q <= ar;
				end
			end
			S_MULW: if (mstat.done) res_q <= mprod;
			S_RADD: res_q <= ar;
			S_PSQ_W, S_PMU_W: begin
				if (mstat.done) begin
					acc_q <= mprod;
					res_q <= mprod;
				end
			end
			S_CHK_W: begin
				if (mstat.done) begin
					// root candidate checked by squaring it back
					if (mprod == ra_q) begin
						res_q <= acc_q;
					end else begin
						res_q  <= '0;
						stat_q <= ST_NONRES;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_res_q  <= res_q;
					out_stat_q <= stat_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid     = out_vld_q;
	assign rsp.res_limb0 = out_res_q[63:0];
	assign rsp.res_limb1 = out_res_q[127:64];
	assign rsp.res_limb2 = out_res_q[191:128];
	assign rsp.res_limb3 = out_res_q[255:192];
	assign rsp.status    = out_stat_q;

	// multiplier started only when free
	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		m_start |-> !mstat.busy)
		else $error("multiplier started while busy");

	// completion seen only while waiting for it
	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mstat.done |-> (state_q == S_MULW || state_q == S_PSQ_W ||
			state_q == S_PMU_W || state_q == S_CHK_W))
		else $error("multiplier result not expected");

	// an error status always carries a zero result
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_stat_q != ST_OK) |-> (out_res_q == '0))
		else $error("error status with nonzero result");
endmodule

// ===== tb/tb_secp256k1_field_alu.sv =====
// self-checking testbench of the secp256k1 field arithmetic unit
module tb_secp256k1_field_alu;
	timeunit 1ns;
	timeprecision 1ps;
	import sfa_pkg::*;

	typedef struct {
		logic [2:0] op;
		elem_t      a;
		elem_t      b;
		bit         typed;  // expectation written into the table
		elem_t      res;
		logic [1:0] st;
	} stim_row_t;

	typedef struct {
		elem_t      res;
		logic [1:0] st;
	} field_res_t;

	localparam elem_t ONES = '1;
	localparam elem_t PM1  = PRIME - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sfa_req_if req();
	sfa_rsp_if rsp();

	secp256k1_field_alu uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// free-running clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	field_res_t pending_res[$];
	int         n_errors = 0;
	int         n_sent = 0;
	int         n_got = 0;
	bit         stim_done = 1'b0;

	// ---------------------------------------------------------------
	// field arithmetic predictor, plain wide-integer maths mod P
	// ---------------------------------------------------------------
	function automatic elem_t fmul(elem_t x, elem_t y);
		logic [511:0] w;
		w = 512'(x) * 512'(y);
		return elem_t'(w % 512'(PRIME));
	endfunction

	function automatic elem_t fexp(elem_t base, elem_t e);
		elem_t acc;
		acc = 1;
		for (int i = 255; i >= 0; i--) begin
			acc = fmul(acc, acc);
			if (e[i]) acc = fmul(acc, base);
		end
		return acc;
	endfunction

	function automatic field_res_t field_predict(logic [2:0] op, elem_t a, elem_t b);
		field_res_t r;
		elem_t ra, rb, root;
		logic [511:0] wide;
		ra = a % PRIME;
		rb = b % PRIME;
		r.res = '0;
		r.st = ST_OK;
		case (op)
			OP_ADD: r.res = elem_t'((257'(ra) + 257'(rb)) % 257'(PRIME));
			OP_SUB: r.res = (ra >= rb) ? ra - rb : (PRIME - rb) + ra;
			OP_NEG: r.res = (ra == 0) ? '0 : PRIME - ra;
			OP_MUL: r.res = fmul(a, b);
			OP_SQR: r.res = fmul(a, a);
			OP_RED: begin
				wide = {b, a};
				r.res = elem_t'(wide % 512'(PRIME));
			end
			OP_INV: begin
				// zero has no inverse: flag it, result stays zero
				if (ra == 0) r.st = ST_INVZERO;
				else r.res = fexp(ra, EXP_INV);
			end
			default: begin
				// P = 3 mod 4, so a^((P+1)/4) is a root when one exists
				root = fexp(ra, EXP_SQRT);
				if (fmul(root, root) == ra) r.res = root;
				else r.st = ST_NONRES;
			end
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------
	// operand generator: a mix of plain random, near-P and edge values
	// ---------------------------------------------------------------
	function automatic elem_t rand_operand();
		elem_t v;
		for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
		case ($urandom_range(0, 5))
			0: v = v % PRIME;
			1: v = PRIME - 256'($urandom_range(0, 3));
			2: v = PRIME + 256'($urandom_range(0, 976));
			3: v = 256'($urandom_range(0, 3));
			4: v = ONES - 256'($urandom_range(0, 2));
			default: ;
		endcase
		return v;
	endfunction

	// ---------------------------------------------------------------
	// directed table: edges, every operation, every error case
	// ---------------------------------------------------------------
	stim_row_t dir_rows[$];

	function automatic stim_row_t mk(logic [2:0] op, elem_t a, elem_t b, bit typed = 0,
		elem_t res = '0, logic [1:0] st = ST_OK);
		stim_row_t r;
		r.op = op; r.a = a; r.b = b; r.typed = typed; r.res = res; r.st = st;
		return r;
	endfunction

	initial begin
		dir_rows.push_back(mk(OP_ADD, 0, 0, 1, 0));
		dir_rows.push_back(mk(OP_ADD, PM1, 1, 1, 0));
		dir_rows.push_back(mk(OP_ADD, ONES, ONES));
		dir_rows.push_back(mk(OP_SUB, 0, 1, 1, PM1));
		dir_rows.push_back(mk(OP_SUB, PRIME, 0, 1, 0));
		dir_rows.push_back(mk(OP_SUB, 5, ONES));
		dir_rows.push_back(mk(OP_NEG, 0, ONES, 1, 0));
		dir_rows.push_back(mk(OP_NEG, 1, 0, 1, PM1));
		dir_rows.push_back(mk(OP_NEG, ONES, 7));
		dir_rows.push_back(mk(OP_MUL, PM1, PM1, 1, 1));
		dir_rows.push_back(mk(OP_MUL, ONES, ONES));
		dir_rows.push_back(mk(OP_SQR, elem_t'(1) << 255, ONES));
		dir_rows.push_back(mk(OP_RED, ONES, ONES));
		dir_rows.push_back(mk(OP_RED, 0, 1, 1, FOLD_C));
		dir_rows.push_back(mk(OP_RED, PRIME, 0, 1, 0));
		// inverse of zero, also when the operand is P itself
		dir_rows.push_back(mk(OP_INV, 0, ONES, 1, 0, ST_INVZERO));
		dir_rows.push_back(mk(OP_INV, PRIME, 0, 1, 0, ST_INVZERO));
		dir_rows.push_back(mk(OP_INV, 2, 0));
		dir_rows.push_back(mk(OP_SQRT, 0, ONES, 1, 0, ST_OK));
		// minus one is not a residue since P = 3 mod 4
		dir_rows.push_back(mk(OP_SQRT, PM1, 0, 1, 0, ST_NONRES));
		dir_rows.push_back(mk(OP_SQRT, 4, 0));
	end

	// drive one item from the falling edge until its transfer
	task automatic send_item(stim_row_t row);
		field_res_t e;
		@(negedge clk);
		// random idle cycles, none during the quiet stretch
		if (!(n_sent >= 60 && n_sent < 100))
			while ($urandom_range(0, 99) < 23) begin
				req.valid = 1'b0;
				@(negedge clk);
			end
		req.valid   = 1'b1;
		req.action  = row.op;
		{req.a_limb3, req.a_limb2, req.a_limb1, req.a_limb0} = row.a;
		{req.b_limb3, req.b_limb2, req.b_limb1, req.b_limb0} = row.b;
		do @(posedge clk); while (!req.ready);
		if (row.typed) begin
			e.res = row.res;
			e.st = row.st;
		end else begin
			e = field_predict(row.op, row.a, row.b);
		end
		pending_res.push_back(e);
		n_sent++;
	endtask

	// ---------------------------------------------------------------
	// request side
	// ---------------------------------------------------------------
	initial begin
		stim_row_t row;
		elem_t x;
		req.valid = 1'b0;
		req.action = OP_ADD;
		{req.a_limb3, req.a_limb2, req.a_limb1, req.a_limb0} = '0;
		{req.b_limb3, req.b_limb2, req.b_limb1, req.b_limb0} = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) send_item(dir_rows[i]);

		// random part: fast operations, with one inverse and one root
		for (int k = 0; k < 120; k++) begin
			row = mk(3'($urandom_range(0, 5)), rand_operand(), rand_operand());
			if (k == 50) row.op = OP_INV;
			if (k == 90) begin
				// square of a random element, so the root exists
				x = rand_operand();
				row.op = OP_SQRT;
				row.a = fmul(x, x);
			end
			send_item(row);
		end
		@(negedge clk);
		req.valid = 1'b0;
		stim_done = 1'b1;
	end

	// ---------------------------------------------------------------
	// response side: random back-pressure plus one long hold-off
	// ---------------------------------------------------------------
	initial begin
		bit held = 1'b0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && n_got == 40) begin
				// hold the output while the sender keeps offering
				held = 1'b1;
				rsp.ready = 1'b0;
				repeat (3000) @(negedge clk);
			end
			rsp.ready = (n_got >= 70 && n_got < 100) ? 1'b1 : ($urandom_range(0, 99) >= 23);
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		field_res_t e;
		elem_t got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = {rsp.res_limb3, rsp.res_limb2, rsp.res_limb1, rsp.res_limb0};
			if (pending_res.size() == 0) begin
				$display("%0t: unexpected result %h status %0d", $realtime, got, rsp.status);
				n_errors++;
			end else begin
				e = pending_res.pop_front();
				if (got !== e.res) begin
					$display("%0t: result expected %h actual %h", $realtime, e.res, got);
					n_errors++;
				end
				if (rsp.status !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $realtime, e.st,
						rsp.status);
					n_errors++;
				end
			end
			n_got++;
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		wait (pending_res.size() == 0);
		repeat (600) @(posedge clk);
		if (n_errors == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

	// watchdog, well beyond the slowest legal run
	initial begin
		#80ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== secp256k1_field_alu.f =====
hdl/sfa_pkg.sv
hdl/sfa_if.sv
hdl/sfa_modadd.sv
hdl/sfa_mulser.sv
hdl/secp256k1_field_alu.sv
tb/tb_secp256k1_field_alu.sv
